@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define MKTD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define MKTD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/mktd_pkg.sv @@
// shared types, constants and the letter table of the morse key timing decoder
package mktd_pkg;

    localparam int MAX_ELEMENTS = 4;
    localparam int SLOT_W       = 3;
    localparam int CNT_W        = 16;
    localparam int CHAR_W       = 7;
    localparam int CFG_IDX_W    = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DASH        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_GAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP    = 3'd4;

    // element codes
    localparam logic [1:0] ELEM_NONE = 2'd0;
    localparam logic [1:0] ELEM_DOT  = 2'd1;
    localparam logic [1:0] ELEM_DASH = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_A         = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_WORD_SEP  = 7'h5F;

    // results of one accepted tick, handed from the core to the output queue
    typedef struct packed {
        logic [1:0]        cnt;
        logic [CHAR_W-1:0] ch0;
        logic [CHAR_W-1:0] ch1;
    } t_push;

    typedef struct packed {
        logic              found;
        logic [CHAR_W-1:0] ch;
    } t_lookup;

    // base-3 element code to letter
    function automatic t_lookup letter_lookup(input logic [6:0] code);
        t_lookup r;
        logic [4:0] idx;
        r.found = 1'b1;
        idx     = 5'd0;
        unique case (code)
            7'd45: idx = 5'd0;
            7'd67: idx = 5'd1;
            7'd70: idx = 5'd2;
            7'd66: idx = 5'd3;
            7'd27: idx = 5'd4;
            7'd43: idx = 5'd5;
            7'd75: idx = 5'd6;
            7'd40: idx = 5'd7;
            7'd36: idx = 5'd8;
            7'd53: idx = 5'd9;
            7'd69: idx = 5'd10;
            7'd49: idx = 5'd11;
            7'd72: idx = 5'd12;
            7'd63: idx = 5'd13;
            7'd78: idx = 5'd14;
            7'd52: idx = 5'd15;
            7'd77: idx = 5'd16;
            7'd48: idx = 5'd17;
            7'd39: idx = 5'd18;
            7'd54: idx = 5'd19;
            7'd42: idx = 5'd20;
            7'd41: idx = 5'd21;
            7'd51: idx = 5'd22;
            7'd68: idx = 5'd23;
            7'd71: idx = 5'd24;
            7'd76: idx = 5'd25;
            default: r.found = 1'b0;
        endcase
        r.ch = CHAR_A + {2'b00, idx};
        return r;
    endfunction

endpackage

@@ hw/rtl/mktd_core.sv @@
// timing counters, element store, gap classification and configuration registers
module mktd_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mktd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mktd_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                          i_accept,
    input  logic                          i_key,
    output mktd_pkg::t_push               o_push
);
    import mktd_pkg::*;

    logic [CNT_W-1:0]  r_min_press, r_dash, r_elem_gap, r_letter_gap, r_word_gap;
    logic              r_key_prev, n_key_prev;
    logic [CNT_W-1:0]  r_press_cnt, n_press_cnt;
    logic [CNT_W-1:0]  r_gap_cnt, n_gap_cnt;
    logic [1:0]        r_elem [MAX_ELEMENTS];
    logic [1:0]        n_elem [MAX_ELEMENTS];
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_gap_valid, n_gap_valid;

    logic [6:0]        code;
    t_lookup           lk;
    logic              do_flush, do_sep, slot_free;
    logic [CNT_W-1:0]  eff_press;
    logic [1:0]        elem_new;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_press  <= 16'd10;
            r_dash       <= 16'd60;
            r_elem_gap   <= 16'd20;
            r_letter_gap <= 16'd60;
            r_word_gap   <= 16'd300;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MIN_PRESS:   r_min_press  <= i_cfg_data;
                REG_DASH:        r_dash       <= i_cfg_data;
                REG_ELEMENT_GAP: r_elem_gap   <= i_cfg_data;
                REG_LETTER_GAP:  r_letter_gap <= i_cfg_data;
                REG_WORD_GAP:    r_word_gap   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // base-3 code of the stored letter, first element most significant
    assign code = 7'(r_elem[0]) * 7'd27 + 7'(r_elem[1]) * 7'd9
                + 7'(r_elem[2]) * 7'd3 + 7'(r_elem[3]);
    assign lk        = letter_lookup(code);
    assign slot_free = (r_slot < SLOT_W'(MAX_ELEMENTS));
    assign eff_press = (r_press_cnt < r_min_press) ? r_min_press : r_press_cnt;
    assign elem_new  = (eff_press >= r_dash) ? ELEM_DASH : ELEM_DOT;

    // next state for one key sample
    always_comb begin
        n_key_prev  = i_key;
        n_press_cnt = r_press_cnt;
        n_gap_cnt   = r_gap_cnt;
        n_elem      = r_elem;
        n_slot      = r_slot;
        n_gap_valid = r_gap_valid;
        do_flush    = 1'b0;
        do_sep      = 1'b0;
        if (i_key) begin
            if (!r_key_prev) begin
                // press starts: classify the gap that just ended
                if (r_gap_valid) begin
                    priority if (r_gap_cnt >= r_word_gap) begin
                        do_flush = 1'b1;
                        do_sep   = 1'b1;
                    end else if (r_gap_cnt >= r_letter_gap) begin
                        do_flush = 1'b1;
                    end else if (r_gap_cnt >= r_elem_gap) begin
                        if (slot_free) n_slot = r_slot + 3'd1;
                    end
                end
                n_press_cnt = 16'd1;
            end else begin
                n_press_cnt = (r_press_cnt == 16'hFFFF) ? r_press_cnt : r_press_cnt + 16'd1;
            end
        end else begin
            if (r_key_prev) begin
                // release: store the element, or flush on an overlong letter
                if (slot_free) begin
                    n_elem[r_slot[1:0]] = elem_new;
                    n_gap_valid         = 1'b1;
                end else begin
                    do_flush = 1'b1;
                end
                n_gap_cnt = 16'd1;
            end else begin
                n_gap_cnt = (r_gap_cnt == 16'hFFFF) ? r_gap_cnt : r_gap_cnt + 16'd1;
            end
        end
        if (do_flush) begin
            for (int k = 0; k < MAX_ELEMENTS; k++) n_elem[k] = ELEM_NONE;
            n_slot      = '0;
            n_gap_valid = 1'b0;
        end
    end

    // results of this sample
    always_comb begin
        o_push.cnt = 2'd0;
        o_push.ch0 = CHAR_WORD_SEP;
        o_push.ch1 = CHAR_WORD_SEP;
        if (i_accept) begin
            if (do_flush && lk.found) begin
                o_push.ch0 = lk.ch;
                o_push.cnt = do_sep ? 2'd2 : 2'd1;
            end else if (do_sep) begin
                o_push.cnt = 2'd1;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_prev  <= 1'b0;
            r_press_cnt <= '0;
            r_gap_cnt   <= '0;
            r_slot      <= '0;
            r_gap_valid <= 1'b0;
            for (int k = 0; k < MAX_ELEMENTS; k++) r_elem[k] <= ELEM_NONE;
        end else if (i_accept) begin
            r_key_prev  <= n_key_prev;
            r_press_cnt <= n_press_cnt;
            r_gap_cnt   <= n_gap_cnt;
            r_slot      <= n_slot;
            r_gap_valid <= n_gap_valid;
            r_elem      <= n_elem;
        end
    end

endmodule

@@ hw/rtl/mktd_fifo.sv @@
// four-entry result queue that takes up to two results per cycle and hands out one
module mktd_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mktd_pkg::t_push              i_push,
    output logic                         o_room,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mktd_pkg::CHAR_W-1:0]  o_char,
    output logic                         o_last
);
    import mktd_pkg::*;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);

    logic [CHAR_W:0]  r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [PTR_W:0]   r_count, n_count;
    logic             pop;
    logic [PTR_W-1:0] wp1;

    assign pop     = o_valid & i_ready;
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= (PTR_W+1)'(QDEPTH - 2));
    assign o_char  = r_mem[r_rp][CHAR_W-1:0];
    assign o_last  = r_mem[r_rp][CHAR_W];
    assign wp1     = r_wp + PTR_W'(1);

    // pointer and fill bookkeeping
    always_comb begin
        n_wp    = r_wp + PTR_W'(i_push.cnt);
        n_rp    = pop ? r_rp + PTR_W'(1) : r_rp;
        n_count = r_count + (PTR_W+1)'(i_push.cnt) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // entry writes, last flag on the final result of the tick
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= {(i_push.cnt == 2'd1), i_push.ch0};
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp1] <= {1'b1, i_push.ch1};
        end
    end

endmodule

@@ hw/rtl/morse_key_timing_decoder.sv @@
// Morse key timing decoder: one key sample per tick in, decoded letters out
//
// Slave stream i_s_*: one key sample per transfer, i_s_tdata[0] = key_down.
// Master stream o_m_*: one decoded character per transfer, o_m_tdata[6:0] is
// ASCII 'A'..'Z' or '_' as word separator, o_m_tlast marks the final result
// caused by one sample. A sample causes zero, one or two results.
// Configuration channel i_cfg_*: register index and 16-bit value, always ready;
// write only while no results are pending.
// Throughput: one sample per cycle while o_s_tready is high. The sample is
// classified in the cycle it is accepted and its results are registered into the queue.
// A four-entry result queue parts the two sides; o_s_tready stays high while
// it holds two entries or fewer, so a stalled receiver holds off new samples
// only once the queue holds three entries or more, and every result waits until taken.
// Reset (i_rst_n low at a clock edge) clears the counters, element store and
// queue, and loads the default thresholds 10, 60, 20, 60, 300 ticks.
module morse_key_timing_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [0] key_down, [7:1] zero
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [7:0]                     o_m_tdata,   // [6:0] char_code, [7] zero
    output logic                           o_m_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mktd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mktd_pkg::CNT_W-1:0]     i_cfg_data
);
    import mktd_pkg::*;

    t_push             push;
    logic              room;
    logic              s_accept;
    logic [CHAR_W-1:0] m_char;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = room;
    assign s_accept    = i_s_tvalid & room;
    assign o_m_tdata   = {1'b0, m_char};

    // sample timing and letter classification
    mktd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (s_accept),
        .i_key       (i_s_tdata[0]),
        .o_push      (push)
    );

    // result queue
    mktd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_char  (m_char),
        .o_last  (o_m_tlast)
    );

endmodule

@@ hw/rtl/mktd_checker.sv @@
// port-level checks of the morse key timing decoder, bound to its top level
`include "assert_macros.svh"

module mktd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [7:0]                     i_s_tdata,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [7:0]                     o_m_tdata,
    input logic                           o_m_tlast,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [mktd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [mktd_pkg::CNT_W-1:0]     i_cfg_data
);

    // a stalled result stays offered
    `MKTD_ASSERT(a_valid_holds, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")

    // a stalled result keeps its payload
    `MKTD_ASSERT(a_payload_holds, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast), "payload changed while stalled")

    // reset empties the result queue
    `MKTD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_tvalid, "result offered after reset")

    // every result is a letter or the word separator
    `MKTD_ASSERT(a_char_range, o_m_tvalid |-> (o_m_tdata >= 8'h41 && o_m_tdata <= 8'h5A) || o_m_tdata == 8'h5F, "result is not a letter or separator")

    // the word separator always closes the results of its sample
    `MKTD_ASSERT(a_sep_last, o_m_tvalid && o_m_tdata == 8'h5F |-> o_m_tlast, "separator without last flag")

endmodule

bind morse_key_timing_decoder mktd_checker u_mktd_checker (.*);
